// ===== rtl/imu7_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu7_pkg
// Shared types and constants for the modified UTF-7 mailbox name decoder.
// ----------------------------------------------------------------------------
package imu7_pkg;

	localparam logic [7:0] CHAR_AMP  = 8'h26;
	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam int unsigned CP_W = 21;

	localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	localparam logic [CP_W-1:0] LIM_1B = 21'h00007F;
	localparam logic [CP_W-1:0] LIM_2B = 21'h0007FF;
	localparam logic [CP_W-1:0] LIM_3B = 21'h00FFFF;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_MARK = 8'h80;

	// what the back end has to do with one queued word
	typedef enum logic [1:0] {
		JOB_RAW  = 2'd0,
		JOB_CP   = 2'd1,
		JOB_MARK = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t       kind;
		logic [CP_W-1:0] cp;    // raw byte sits in cp[7:0]
		logic            last;  // word came from the final byte of the name
	} job_t;

	typedef enum logic [2:0] {
		MODE_LIT = 3'b001,
		MODE_AMP = 3'b010,
		MODE_B64 = 3'b100
	} mode_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} b64_t;

	function automatic b64_t b64_decode(input logic [7:0] b);
		b64_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r.val = 6'(b - 8'h41);
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			r.val = 6'(b - 8'h61 + 8'd26);
		end else if (b >= 8'h30 && b <= 8'h39) begin
			r.val = 6'(b - 8'h30 + 8'd52);
		end else if (b == CHAR_PLUS) begin
			r.val = 6'd62;
		end else if (b == CHAR_COMMA) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/imap_utf7_to_utf8_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imap_utf7_to_utf8_decoder_top
// IMAP modified UTF-7 mailbox name decoder, one encoded byte in, UTF-8 out.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle whenever the job queue has room; the
// front end updates the escape/base64 state in that same cycle. Each byte
// that yields output places one job in a QUEUE_DEPTH-entry queue, and the
// serializer drains it at one output word per cycle while out_stall is low:
// a literal byte or an escaped '&' gives one word, a decoded code point 1 to
// 4 words, and a silent last byte of a name one end marker (byte_valid low).
// Input bytes that yield nothing do not use the queue. Sustained input rate
// is one byte per cycle when out_stall is low and each byte yields at most
// one output word; runs of multi-byte characters are bound by the serializer.
// ----------------------------------------------------------------------------
module imap_utf7_to_utf8_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_name,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last_of_item,
	output logic             name_done
);

	logic            accept;
	logic            push;
	imu7_pkg::job_t  push_data;
	logic            pop;
	imu7_pkg::job_t  head;
	logic            head_valid;
	logic            full;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	imu7_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.end_of_name (end_of_name),
		.push        (push),
		.push_data   (push_data)
	);

	imu7_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	imu7_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last_of_item (last_of_item),
		.name_done    (name_done)
	);

endmodule
`default_nettype wire

// ===== rtl/imu7_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu7_front
// Takes one encoded byte per accepted cycle, tracks escape and base64 state,
// and produces one job per byte that has something to emit or ends a name.
// ----------------------------------------------------------------------------
module imu7_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 end_of_name,
	output logic                      push,
	output imu7_pkg::job_t            push_data
);

	imu7_pkg::mode_t               mode_q, mode_n;
	logic [21:0]                   buf_q, buf_n;
	logic [4:0]                    cnt_q, cnt_n;
	logic [imu7_pkg::CP_W-1:0]     cp_q, cp_n;

	logic                          run, lit, emit;
	logic [21:0]                   run_buf;
	logic [4:0]                    run_cnt;
	logic [imu7_pkg::CP_W-1:0]     run_cp;
	imu7_pkg::b64_t                dec;
	logic [21:0]                   sh_buf;
	logic [4:0]                    sh_cnt;
	logic [4:0]                    rem_cnt;
	logic [21:0]                   aligned;
	logic [15:0]                   unit;
	imu7_pkg::job_kind_t           kind;
	logic [imu7_pkg::CP_W-1:0]     job_cp;

	// a run starts from a clean buffer
	assign run_buf = (mode_q == imu7_pkg::MODE_AMP) ? '0 : buf_q;
	assign run_cnt = (mode_q == imu7_pkg::MODE_AMP) ? '0 : cnt_q;
	assign run_cp  = (mode_q == imu7_pkg::MODE_AMP) ? '0 : cp_q;

	assign dec     = imu7_pkg::b64_decode(in_byte);
	assign sh_buf  = {run_buf[15:0], dec.val};
	assign sh_cnt  = run_cnt + 5'd6;
	assign rem_cnt = sh_cnt - 5'd16;
	assign aligned = sh_buf >> rem_cnt;
	assign unit    = aligned[15:0];

	always_comb begin
		mode_n  = mode_q;
		buf_n   = buf_q;
		cnt_n   = cnt_q;
		cp_n    = cp_q;
		run     = 1'b0;
		lit     = 1'b0;
		emit    = 1'b0;
		kind    = imu7_pkg::JOB_RAW;
		job_cp  = {13'd0, in_byte};

		case (mode_q)
			imu7_pkg::MODE_LIT: begin
				lit = 1'b1;
			end
			imu7_pkg::MODE_AMP: begin
				if (in_byte == imu7_pkg::CHAR_DASH) begin
					mode_n = imu7_pkg::MODE_LIT;
					emit   = 1'b1;
					job_cp = {13'd0, imu7_pkg::CHAR_AMP};
				end else begin
					run     = 1'b1;
					buf_n   = '0;
					cnt_n   = '0;
					cp_n    = '0;
					mode_n  = imu7_pkg::MODE_B64;
				end
			end
			imu7_pkg::MODE_B64: begin
				run = 1'b1;
			end
			default: begin
				mode_n = imu7_pkg::MODE_LIT;
			end
		endcase

		if (run) begin
			if (dec.ok) begin
				buf_n = sh_buf;
				if (sh_cnt >= 5'd16) begin
					cnt_n = rem_cnt;
					if (unit[15:10] == imu7_pkg::SUR_HIGH_TAG) begin
						cp_n = {1'b0, unit[9:0], 10'd0};
					end else begin
						if (unit[15:10] == imu7_pkg::SUR_LOW_TAG) begin
							cp_n = run_cp + {11'd0, unit[9:0]} + imu7_pkg::SUPP_BASE;
						end else begin
							cp_n = {5'd0, unit};
						end
						emit   = 1'b1;
						kind   = imu7_pkg::JOB_CP;
						job_cp = cp_n;
					end
				end else begin
					cnt_n = sh_cnt;
				end
			end else begin
				// end of run, leftover bits dropped
				mode_n = imu7_pkg::MODE_LIT;
				if (in_byte != imu7_pkg::CHAR_DASH) begin
					lit = 1'b1;
				end
			end
		end

		if (lit) begin
			if (in_byte == imu7_pkg::CHAR_AMP) begin
				mode_n = imu7_pkg::MODE_AMP;
			end else begin
				mode_n = imu7_pkg::MODE_LIT;
				emit   = 1'b1;
				kind   = imu7_pkg::JOB_RAW;
				job_cp = {13'd0, in_byte};
			end
		end
	end

	assign push           = accept && (emit || end_of_name);
	assign push_data.kind = emit ? kind : imu7_pkg::JOB_MARK;
	assign push_data.cp   = job_cp;
	assign push_data.last = end_of_name;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= imu7_pkg::MODE_LIT;
			buf_q  <= '0;
			cnt_q  <= '0;
			cp_q   <= '0;
		end else if (accept) begin
			if (end_of_name) begin
				mode_q <= imu7_pkg::MODE_LIT;
				buf_q  <= '0;
				cnt_q  <= '0;
				cp_q   <= '0;
			end else begin
				mode_q <= mode_n;
				buf_q  <= buf_n;
				cnt_q  <= cnt_n;
				cp_q   <= cp_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/imu7_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu7_fifo
// Small job queue between the classifying front end and the byte serializer.
// ----------------------------------------------------------------------------
module imu7_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire imu7_pkg::job_t push_data,
	input  wire logic           pop,
	output imu7_pkg::job_t      head,
	output logic                head_valid,
	output logic                full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	imu7_pkg::job_t    mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/imu7_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu7_back
// Serializes queued jobs into UTF-8 bytes, one per cycle while out_stall is
// low, through an output register.
// ----------------------------------------------------------------------------
module imu7_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire imu7_pkg::job_t head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                last_of_item,
	output logic                name_done
);

	logic [1:0]  idx_q;
	logic [1:0]  last_idx;
	logic [7:0]  cur_byte;
	logic        load;
	logic        at_end;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic        last_of_item_q;
	logic        name_done_q;

	// number of bytes minus one, and the byte at the current position
	always_comb begin
		last_idx = 2'd0;
		cur_byte = 8'd0;
		case (head.kind)
			imu7_pkg::JOB_RAW: begin
				cur_byte = head.cp[7:0];
			end
			imu7_pkg::JOB_CP: begin
				if (head.cp <= imu7_pkg::LIM_1B) begin
					last_idx = 2'd0;
					cur_byte = {1'b0, head.cp[6:0]};
				end else if (head.cp <= imu7_pkg::LIM_2B) begin
					last_idx = 2'd1;
					cur_byte = (idx_q == 2'd0)
						? (imu7_pkg::LEAD_2B | {3'd0, head.cp[10:6]})
						: (imu7_pkg::CONT_MARK | {2'd0, head.cp[5:0]});
				end else if (head.cp <= imu7_pkg::LIM_3B) begin
					last_idx = 2'd2;
					case (idx_q)
						2'd0:    cur_byte = imu7_pkg::LEAD_3B | {4'd0, head.cp[15:12]};
						2'd1:    cur_byte = imu7_pkg::CONT_MARK | {2'd0, head.cp[11:6]};
						default: cur_byte = imu7_pkg::CONT_MARK | {2'd0, head.cp[5:0]};
					endcase
				end else begin
					last_idx = 2'd3;
					case (idx_q)
						2'd0:    cur_byte = imu7_pkg::LEAD_4B | {5'd0, head.cp[20:18]};
						2'd1:    cur_byte = imu7_pkg::CONT_MARK | {2'd0, head.cp[17:12]};
						2'd2:    cur_byte = imu7_pkg::CONT_MARK | {2'd0, head.cp[11:6]};
						default: cur_byte = imu7_pkg::CONT_MARK | {2'd0, head.cp[5:0]};
					endcase
				end
			end
			default: begin
				// end marker
				cur_byte = 8'd0;
			end
		endcase
	end

	assign load   = head_valid && (!out_valid_q || !out_stall);
	assign at_end = (idx_q == last_idx);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= cur_byte;
			byte_valid_q   <= (head.kind != imu7_pkg::JOB_MARK);
			last_of_item_q <= at_end;
			name_done_q    <= at_end && head.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign last_of_item = last_of_item_q;
	assign name_done    = name_done_q;

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 2'd0)
		else $error("serializer position not at zero with empty queue");

	a_idx_mb: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && idx_q != 2'd0 |-> head.kind == imu7_pkg::JOB_CP)
		else $error("multi-byte position on a single-byte job");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && name_done_q |-> last_of_item_q)
		else $error("name_done without last_of_item");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !byte_valid_q |-> last_of_item_q && name_done_q && out_byte_q == 8'd0)
		else $error("malformed end marker");

endmodule
`default_nettype wire
